@@ rtl/core/bimv_pkg.sv @@
// shared constants and types for the boot image verifier
package bimv_pkg;

    localparam logic [31:0] TEXT_MAX_BYTES = 32'd65536;
    localparam logic [31:0] DATA_MAX_BYTES = 32'd65536;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] IMAGE_MAGIC = 32'h4741_5244;

    localparam int unsigned HEADER_WORDS = 8;
    localparam int unsigned COUNT_W      = 15;
    localparam int unsigned INDEX_W      = 14;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_MAGIC    = 3'd1,
        FAIL_TOO_LONG = 3'd2,
        FAIL_ALIGN    = 3'd3,
        FAIL_ENTRY    = 3'd4,
        FAIL_TEXT_CRC = 3'd5,
        FAIL_DATA_CRC = 3'd6
    } t_fail_code;

    typedef enum logic [2:0] {
        HDR_MAGIC      = 3'd0,
        HDR_TEXT_LEN   = 3'd1,
        HDR_DATA_LEN   = 3'd2,
        HDR_ENTRY      = 3'd3,
        HDR_TEXT_CRC   = 3'd4,
        HDR_DATA_CRC   = 3'd5,
        HDR_RESERVED_0 = 3'd6,
        HDR_RESERVED_1 = 3'd7
    } t_hdr_word;

endpackage

@@ rtl/core/bimv_if.sv @@
// valid/ready channels for flash words in and ram write words out
interface bimv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] flash_word;
    logic        restart;

    modport source (output valid, output flash_word, output restart, input ready);
    modport sink   (input valid, input flash_word, input restart, output ready);
endinterface

interface bimv_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ram_write;
    logic                          ram_select;
    logic [bimv_pkg::INDEX_W-1:0]  ram_word_index;
    logic [31:0]                   ram_data;
    logic                          done_res;
    logic                          pass;
    logic [2:0]                    fail_code;
    logic [31:0]                   entry_point;

    modport source (
        output valid, output ram_write, output ram_select, output ram_word_index,
        output ram_data, output done_res, output pass, output fail_code,
        output entry_point, input ready
    );
    modport sink (
        input valid, input ram_write, input ram_select, input ram_word_index,
        input ram_data, input done_res, input pass, input fail_code,
        input entry_point, output ready
    );
endinterface

@@ rtl/core/bimv_crc32.sv @@
// reflected crc-32 update over one 32-bit word, low byte first
module bimv_crc32 (
    input  logic [31:0] i_crc,
    input  logic [31:0] i_word,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ i_word;
        for (int k = 0; k < 32; k++) begin
            c = (c >> 1) ^ (bimv_pkg::CRC_POLY & {32{c[0]}});
        end
        o_crc = c;
    end

endmodule

@@ rtl/core/boot_image_verifier.sv @@
// boot image verifier top level: header checks, ram write stream and region crcs
// the result word for an accepted flash word is registered and offered in the next cycle
// throughput: one flash word per cycle while the ram side takes each result word, set by the one-word crc update
// a new word is taken in the same cycle as the waiting result word is taken
// reset (synchronous, active low) returns to header word zero, crc all ones
module boot_image_verifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bimv_in_if.sink            i_in,
    bimv_out_if.source         o_out
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TEXT   = 2'd1,
        PH_DATA   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase                r_phase;
    bimv_pkg::t_count      r_word_count;
    logic [31:0]           r_magic_seen;
    logic [31:0]           r_text_length;
    logic [31:0]           r_data_length;
    logic [31:0]           r_entry_address;
    logic [31:0]           r_text_check;
    logic [31:0]           r_data_check;
    logic [31:0]           r_running_crc;
    logic                  r_text_crc_good;
    bimv_pkg::t_fail_code  r_verdict_code;

    t_phase                n_phase;
    bimv_pkg::t_count      n_word_count;
    logic [31:0]           n_magic_seen;
    logic [31:0]           n_text_length;
    logic [31:0]           n_data_length;
    logic [31:0]           n_entry_address;
    logic [31:0]           n_text_check;
    logic [31:0]           n_data_check;
    logic [31:0]           n_running_crc;
    logic                  n_text_crc_good;
    bimv_pkg::t_fail_code  n_verdict_code;

    logic                          n_ram_write;
    logic                          n_ram_select;
    logic [bimv_pkg::INDEX_W-1:0]  n_ram_word_index;

    logic                          r_out_valid;
    logic                          r_ram_write;
    logic                          r_ram_select;
    logic [bimv_pkg::INDEX_W-1:0]  r_ram_word_index;
    logic [31:0]                   r_ram_data;
    logic                          r_done_res;
    logic                          r_pass;
    logic [2:0]                    r_fail_code;
    logic [31:0]                   r_entry_point;

    logic        accept;
    logic [31:0] crc_in;
    logic [31:0] crc_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // restart folds the reset values in before the word is processed
    assign crc_in = i_in.restart ? bimv_pkg::CRC_ONES : r_running_crc;

    bimv_crc32 u_crc (
        .i_crc  (crc_in),
        .i_word (i_in.flash_word),
        .o_crc  (crc_out)
    );

    always_comb begin
        bimv_pkg::t_count wc_inc;
        bimv_pkg::t_count text_words;
        bimv_pkg::t_count data_words;
        if (i_in.restart) begin
            n_phase         = PH_HEADER;
            n_word_count    = '0;
            n_magic_seen    = '0;
            n_text_length   = '0;
            n_data_length   = '0;
            n_entry_address = '0;
            n_text_check    = '0;
            n_data_check    = '0;
            n_running_crc   = bimv_pkg::CRC_ONES;
            n_text_crc_good = 1'b0;
            n_verdict_code  = bimv_pkg::FAIL_NONE;
        end else begin
            n_phase         = r_phase;
            n_word_count    = r_word_count;
            n_magic_seen    = r_magic_seen;
            n_text_length   = r_text_length;
            n_data_length   = r_data_length;
            n_entry_address = r_entry_address;
            n_text_check    = r_text_check;
            n_data_check    = r_data_check;
            n_running_crc   = r_running_crc;
            n_text_crc_good = r_text_crc_good;
            n_verdict_code  = r_verdict_code;
        end

        n_ram_write      = 1'b0;
        n_ram_select     = 1'b0;
        n_ram_word_index = '0;

        wc_inc     = n_word_count + bimv_pkg::t_count'(1);
        text_words = n_text_length[bimv_pkg::COUNT_W+1:2];
        data_words = n_data_length[bimv_pkg::COUNT_W+1:2];

        unique case (n_phase)
            PH_HEADER: begin
                unique case (bimv_pkg::t_hdr_word'(n_word_count[2:0]))
                    bimv_pkg::HDR_MAGIC:    n_magic_seen    = i_in.flash_word;
                    bimv_pkg::HDR_TEXT_LEN: n_text_length   = i_in.flash_word;
                    bimv_pkg::HDR_DATA_LEN: n_data_length   = i_in.flash_word;
                    bimv_pkg::HDR_ENTRY:    n_entry_address = i_in.flash_word;
                    bimv_pkg::HDR_TEXT_CRC: n_text_check    = i_in.flash_word;
                    bimv_pkg::HDR_DATA_CRC: n_data_check    = i_in.flash_word;
                    default: ;
                endcase
                n_word_count = wc_inc;
                if (wc_inc == bimv_pkg::t_count'(bimv_pkg::HEADER_WORDS)) begin
                    n_word_count  = '0;
                    n_running_crc = bimv_pkg::CRC_ONES;
                    priority if (n_magic_seen != bimv_pkg::IMAGE_MAGIC) begin
                        n_verdict_code = bimv_pkg::FAIL_MAGIC;
                    end else if (n_text_length > bimv_pkg::TEXT_MAX_BYTES ||
                                 n_data_length > bimv_pkg::DATA_MAX_BYTES) begin
                        n_verdict_code = bimv_pkg::FAIL_TOO_LONG;
                    end else if ((n_text_length[1:0] | n_data_length[1:0]) != 2'b00) begin
                        n_verdict_code = bimv_pkg::FAIL_ALIGN;
                    end else if (n_entry_address >= n_text_length) begin
                        n_verdict_code = bimv_pkg::FAIL_ENTRY;
                    end else begin
                        n_verdict_code = bimv_pkg::FAIL_NONE;
                    end
                    n_phase = (n_verdict_code != bimv_pkg::FAIL_NONE) ? PH_DONE : PH_TEXT;
                end
            end
            PH_TEXT: begin
                n_ram_write      = 1'b1;
                n_ram_select     = 1'b0;
                n_ram_word_index = n_word_count[bimv_pkg::INDEX_W-1:0];
                n_running_crc    = crc_out;
                n_word_count     = wc_inc;
                if (wc_inc >= text_words) begin
                    n_text_crc_good = (~crc_out == n_text_check);
                    n_running_crc   = bimv_pkg::CRC_ONES;
                    n_word_count    = '0;
                    if (n_data_length == '0) begin
                        // empty data region compares a zero crc
                        priority if (!n_text_crc_good) begin
                            n_verdict_code = bimv_pkg::FAIL_TEXT_CRC;
                        end else if (n_data_check != '0) begin
                            n_verdict_code = bimv_pkg::FAIL_DATA_CRC;
                        end else begin
                            n_verdict_code = bimv_pkg::FAIL_NONE;
                        end
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_ram_write      = 1'b1;
                n_ram_select     = 1'b1;
                n_ram_word_index = n_word_count[bimv_pkg::INDEX_W-1:0];
                n_running_crc    = crc_out;
                n_word_count     = wc_inc;
                if (wc_inc >= data_words) begin
                    priority if (!n_text_crc_good) begin
                        n_verdict_code = bimv_pkg::FAIL_TEXT_CRC;
                    end else if (~crc_out != n_data_check) begin
                        n_verdict_code = bimv_pkg::FAIL_DATA_CRC;
                    end else begin
                        n_verdict_code = bimv_pkg::FAIL_NONE;
                    end
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HEADER;
            r_word_count    <= '0;
            r_magic_seen    <= '0;
            r_text_length   <= '0;
            r_data_length   <= '0;
            r_entry_address <= '0;
            r_text_check    <= '0;
            r_data_check    <= '0;
            r_running_crc   <= bimv_pkg::CRC_ONES;
            r_text_crc_good <= 1'b0;
            r_verdict_code  <= bimv_pkg::FAIL_NONE;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_word_count    <= n_word_count;
                r_magic_seen    <= n_magic_seen;
                r_text_length   <= n_text_length;
                r_data_length   <= n_data_length;
                r_entry_address <= n_entry_address;
                r_text_check    <= n_text_check;
                r_data_check    <= n_data_check;
                r_running_crc   <= n_running_crc;
                r_text_crc_good <= n_text_crc_good;
                r_verdict_code  <= n_verdict_code;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ram_write      <= n_ram_write;
            r_ram_select     <= n_ram_select;
            r_ram_word_index <= n_ram_word_index;
            r_ram_data       <= n_ram_write ? i_in.flash_word : '0;
            r_done_res       <= (n_phase == PH_DONE);
            r_pass           <= (n_phase == PH_DONE) &&
                                (n_verdict_code == bimv_pkg::FAIL_NONE);
            r_fail_code      <= (n_phase == PH_DONE) ? n_verdict_code : bimv_pkg::FAIL_NONE;
            r_entry_point    <= (n_phase == PH_DONE) ? n_entry_address : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.ram_write      = r_ram_write;
    assign o_out.ram_select     = r_ram_select;
    assign o_out.ram_word_index = r_ram_word_index;
    assign o_out.ram_data       = r_ram_data;
    assign o_out.done_res       = r_done_res;
    assign o_out.pass           = r_pass;
    assign o_out.fail_code      = r_fail_code;
    assign o_out.entry_point    = r_entry_point;

endmodule

@@ dv/tb_boot_image_verifier.sv @@
// testbench for the boot image verifier: image stream stimulus, ram command predictor, checks
module tb_boot_image_verifier;
    import bimv_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned RANDOM_WORDS = 1500;
    localparam int unsigned HOLD_START   = 1000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int          NUM_CASES    = 17;

    typedef enum logic [1:0] {
        LOAD_HEADER,
        LOAD_TEXT,
        LOAD_DATA,
        LOAD_DONE
    } t_load_phase;

    typedef struct packed {
        logic               ram_write;
        logic               ram_select;
        logic [INDEX_W-1:0] ram_word_index;
        logic [31:0]        ram_data;
        logic               done_res;
        logic               pass;
        t_fail_code         fail_code;
        logic [31:0]        entry_point;
    } t_ram_cmd;

    typedef struct packed {
        logic        restart;
        logic [31:0] magic;
        logic [31:0] text_bytes;
        logic [31:0] data_bytes;
        logic [31:0] entry;
        logic        bad_text_crc;
        logic        bad_data_crc;
        t_fail_code  verdict;
    } t_image_case;

    typedef struct {
        logic [31:0] word;
        logic        restart;
        logic        typed;
        t_ram_cmd    want;
    } t_flash_item;

    logic i_clk;
    logic i_rst_n;

    bimv_in_if  in_bus ();
    bimv_out_if out_bus ();

    boot_image_verifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_image_case image_cases [NUM_CASES] = '{
        '{1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_MAGIC},
        '{1'b1, 32'h0000_0000, 32'h0000_0004, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_MAGIC},
        '{1'b1, IMAGE_MAGIC, 32'h0001_0004, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_TOO_LONG},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0001_0004, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_TOO_LONG},
        '{1'b1, IMAGE_MAGIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
          FAIL_TOO_LONG},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0006, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_ALIGN},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_ALIGN},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0000_0000, 32'h0000_0008, 1'b0, 1'b0,
          FAIL_ENTRY},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0000_0008, 32'hFFFF_FFFF, 1'b0, 1'b0,
          FAIL_ENTRY},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0000, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_ENTRY},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0004, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
          FAIL_NONE},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0004, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
          FAIL_DATA_CRC},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0000_0008, 32'h0000_0004, 1'b0, 1'b0,
          FAIL_NONE},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0008, 32'h0000_000C, 32'h0000_0004, 1'b1, 1'b0,
          FAIL_TEXT_CRC},
        '{1'b1, IMAGE_MAGIC, 32'h0000_000C, 32'h0000_0008, 32'h0000_0000, 1'b0, 1'b1,
          FAIL_DATA_CRC},
        '{1'b1, IMAGE_MAGIC, 32'h0000_0004, 32'h0000_0004, 32'h0000_0000, 1'b1, 1'b1,
          FAIL_TEXT_CRC},
        '{1'b1, IMAGE_MAGIC, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0,
          FAIL_ENTRY}
    };

    t_flash_item flash_stream [$];
    t_ram_cmd    ram_cmds_due [$];

    t_load_phase load_phase;
    t_count      word_cnt;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_text_bytes;
    logic [31:0] hdr_data_bytes;
    logic [31:0] hdr_entry;
    logic [31:0] hdr_text_crc;
    logic [31:0] hdr_data_crc;
    logic [31:0] region_crc;
    logic        text_crc_ok;
    t_fail_code  verdict;

    t_ram_cmd    predicted_cmd;
    t_ram_cmd    oldest_cmd;
    int          accepted_n;
    int          mismatch_n;
    int unsigned cycle_n;

    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
        for (int i = 0; i < 32; i++) begin
            crc = (crc >> 1) ^ ((crc[0] ^ w[i]) ? CRC_POLY : 32'h0);
        end
        return crc;
    endfunction

    task automatic clear_loader();
        load_phase     = LOAD_HEADER;
        word_cnt       = '0;
        hdr_magic      = '0;
        hdr_text_bytes = '0;
        hdr_data_bytes = '0;
        hdr_entry      = '0;
        hdr_text_crc   = '0;
        hdr_data_crc   = '0;
        region_crc     = CRC_ONES;
        text_crc_ok    = 1'b0;
        verdict        = FAIL_NONE;
    endtask

    task automatic settle_verdict(input logic [31:0] region_sum);
        if (!text_crc_ok) begin
            verdict = FAIL_TEXT_CRC;
        end else if (region_sum != hdr_data_crc) begin
            verdict = FAIL_DATA_CRC;
        end else begin
            verdict = FAIL_NONE;
        end
        load_phase = LOAD_DONE;
    endtask

    task automatic load_word(input logic [31:0] w, input logic rs, output t_ram_cmd cmd);
        logic done;
        cmd = '0;
        if (rs) begin
            clear_loader();
        end
        case (load_phase)
            LOAD_HEADER: begin
                case (t_hdr_word'(word_cnt[2:0]))
                    HDR_MAGIC:    hdr_magic      = w;
                    HDR_TEXT_LEN: hdr_text_bytes = w;
                    HDR_DATA_LEN: hdr_data_bytes = w;
                    HDR_ENTRY:    hdr_entry      = w;
                    HDR_TEXT_CRC: hdr_text_crc   = w;
                    HDR_DATA_CRC: hdr_data_crc   = w;
                    default: ;
                endcase
                word_cnt = word_cnt + 1'b1;
                if (word_cnt == HEADER_WORDS) begin
                    word_cnt   = '0;
                    region_crc = CRC_ONES;
                    if (hdr_magic != IMAGE_MAGIC) begin
                        verdict = FAIL_MAGIC;
                    end else if (hdr_text_bytes > TEXT_MAX_BYTES
                                 || hdr_data_bytes > DATA_MAX_BYTES) begin
                        verdict = FAIL_TOO_LONG;
                    end else if ((hdr_text_bytes[1:0] | hdr_data_bytes[1:0]) != 2'b00) begin
                        verdict = FAIL_ALIGN;
                    end else if (hdr_entry >= hdr_text_bytes) begin
                        verdict = FAIL_ENTRY;
                    end else begin
                        verdict = FAIL_NONE;
                    end
                    load_phase = (verdict != FAIL_NONE) ? LOAD_DONE : LOAD_TEXT;
                end
            end
            LOAD_TEXT: begin
                cmd.ram_write      = 1'b1;
                cmd.ram_select     = 1'b0;
                cmd.ram_word_index = word_cnt[INDEX_W-1:0];
                cmd.ram_data       = w;
                region_crc         = crc32_word(region_crc, w);
                word_cnt           = word_cnt + 1'b1;
                if (32'(word_cnt) >= (hdr_text_bytes >> 2)) begin
                    text_crc_ok = (~region_crc == hdr_text_crc);
                    region_crc  = CRC_ONES;
                    word_cnt    = '0;
                    if (hdr_data_bytes == 32'h0) begin
                        settle_verdict(32'h0);
                    end else begin
                        load_phase = LOAD_DATA;
                    end
                end
            end
            LOAD_DATA: begin
                cmd.ram_write      = 1'b1;
                cmd.ram_select     = 1'b1;
                cmd.ram_word_index = word_cnt[INDEX_W-1:0];
                cmd.ram_data       = w;
                region_crc         = crc32_word(region_crc, w);
                word_cnt           = word_cnt + 1'b1;
                if (32'(word_cnt) >= (hdr_data_bytes >> 2)) begin
                    settle_verdict(~region_crc);
                end
            end
            default: ;
        endcase
        done            = (load_phase == LOAD_DONE);
        cmd.done_res    = done;
        cmd.pass        = done && (verdict == FAIL_NONE);
        cmd.fail_code   = done ? verdict : FAIL_NONE;
        cmd.entry_point = done ? hdr_entry : 32'h0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatch_n++;
        end
    endtask

    task automatic add_flash_word(input logic [31:0] w, input logic rs, input logic typed,
                                  input t_ram_cmd want);
        t_flash_item item;
        item.word    = w;
        item.restart = rs;
        item.typed   = typed;
        item.want    = want;
        flash_stream.push_back(item);
    endtask

    // header, then text and data words with matching or corrupted crcs; keep < 0 sends all
    task automatic add_image(input logic rs, input logic [31:0] magic, input logic [31:0] tlen,
                             input logic [31:0] dlen, input logic [31:0] entry,
                             input logic bad_t, input logic bad_d, input logic with_body,
                             input int keep, output int emitted);
        logic [31:0] body [$];
        logic [31:0] img [$];
        logic [31:0] tcrc;
        logic [31:0] dcrc;
        logic [31:0] w;
        int          nt;
        int          nd;
        nt   = with_body ? int'(tlen >> 2) : 0;
        nd   = with_body ? int'(dlen >> 2) : 0;
        tcrc = CRC_ONES;
        dcrc = CRC_ONES;
        for (int i = 0; i < nt; i++) begin
            w = $urandom;
            body.push_back(w);
            tcrc = crc32_word(tcrc, w);
        end
        for (int i = 0; i < nd; i++) begin
            w = $urandom;
            body.push_back(w);
            dcrc = crc32_word(dcrc, w);
        end
        tcrc = ~tcrc;
        dcrc = ~dcrc;
        if (bad_t) begin
            tcrc = tcrc ^ (32'h1 << $urandom_range(31, 0));
        end
        if (bad_d) begin
            dcrc = dcrc ^ (32'h1 << $urandom_range(31, 0));
        end
        img.push_back(magic);
        img.push_back(tlen);
        img.push_back(dlen);
        img.push_back(entry);
        img.push_back(tcrc);
        img.push_back(dcrc);
        img.push_back($urandom);
        img.push_back($urandom);
        foreach (body[i]) begin
            img.push_back(body[i]);
        end
        emitted = (keep >= 0 && keep < img.size()) ? keep : img.size();
        for (int i = 0; i < emitted; i++) begin
            add_flash_word(img[i], (i == 0) ? rs : 1'b0, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_loader();
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                load_word(in_bus.flash_word, in_bus.restart, predicted_cmd);
                if (flash_stream[accepted_n].typed) begin
                    ram_cmds_due.push_back(flash_stream[accepted_n].want);
                end else begin
                    ram_cmds_due.push_back(predicted_cmd);
                end
                accepted_n++;
            end
            if (out_bus.valid && out_bus.ready) begin
                if (ram_cmds_due.size() == 0) begin
                    $error("result word with nothing pending");
                    mismatch_n++;
                end else begin
                    oldest_cmd = ram_cmds_due.pop_front();
                    check_field("ram_write", 32'(oldest_cmd.ram_write), 32'(out_bus.ram_write));
                    check_field("ram_select", 32'(oldest_cmd.ram_select),
                                32'(out_bus.ram_select));
                    check_field("ram_word_index", 32'(oldest_cmd.ram_word_index),
                                32'(out_bus.ram_word_index));
                    check_field("ram_data", oldest_cmd.ram_data, out_bus.ram_data);
                    check_field("done_res", 32'(oldest_cmd.done_res), 32'(out_bus.done_res));
                    check_field("pass", 32'(oldest_cmd.pass), 32'(out_bus.pass));
                    check_field("fail_code", 32'(oldest_cmd.fail_code),
                                32'(out_bus.fail_code));
                    check_field("entry_point", oldest_cmd.entry_point, out_bus.entry_point);
                end
            end
        end
    end

    // ram side: free runs, random stalls, mostly stalled runs and one long hold-off
    initial begin
        int   run;
        int   mode;
        logic hold_done;
        out_bus.ready <= 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && cycle_n >= HOLD_START) begin
                hold_done = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(2, 0);
                run  = (mode == 2) ? $urandom_range(12, 1) : $urandom_range(40, 1);
                repeat (run) begin
                    case (mode)
                        0:       out_bus.ready <= 1'b1;
                        1:       out_bus.ready <= ($urandom_range(3, 0) != 0);
                        default: out_bus.ready <= ($urandom_range(7, 0) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int          idx;
        int          burst_left;
        int          gap;
        int          random_start;
        int          image_words;
        int          emitted;
        int          sel;
        int          total;
        int          keep;
        logic [31:0] magic;
        logic [31:0] tlen;
        logic [31:0] dlen;
        logic [31:0] entry;
        logic        bad_t;
        logic        bad_d;
        logic        body;
        t_ram_cmd    want;

        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.flash_word <= 32'h0;
        in_bus.restart    <= 1'b0;
        cycle_n    = 0;
        accepted_n = 0;
        mismatch_n = 0;

        // directed images, each followed by one ignored word with the verdict typed in
        for (int c = 0; c < NUM_CASES; c++) begin
            body = (image_cases[c].verdict == FAIL_NONE)
                || (image_cases[c].verdict == FAIL_TEXT_CRC)
                || (image_cases[c].verdict == FAIL_DATA_CRC);
            add_image(image_cases[c].restart, image_cases[c].magic, image_cases[c].text_bytes,
                      image_cases[c].data_bytes, image_cases[c].entry,
                      image_cases[c].bad_text_crc, image_cases[c].bad_data_crc, body, -1,
                      emitted);
            want             = '0;
            want.done_res    = 1'b1;
            want.pass        = (image_cases[c].verdict == FAIL_NONE);
            want.fail_code   = image_cases[c].verdict;
            want.entry_point = image_cases[c].entry;
            add_flash_word($urandom, 1'b0, 1'b1, want);
        end
        random_start = flash_stream.size();

        // random images: mostly well formed, some broken headers, some cut short by restart
        image_words = 0;
        while (image_words < RANDOM_WORDS) begin
            sel   = $urandom_range(99, 0);
            magic = IMAGE_MAGIC;
            tlen  = 4 * $urandom_range(16, 1);
            dlen  = 4 * $urandom_range(16, 0);
            entry = $urandom_range(tlen - 1, 0);
            bad_t = ($urandom_range(9, 0) == 0);
            bad_d = ($urandom_range(9, 0) == 0);
            body  = 1'b1;
            keep  = -1;
            if (sel >= 85) begin
                total = 8 + int'(tlen >> 2) + int'(dlen >> 2);
                keep  = $urandom_range(total - 1, 1);
            end else if (sel >= 70) begin
                body = 1'b0;
                case ($urandom_range(3, 0))
                    0: magic = $urandom;
                    1: begin
                        tlen = $urandom;
                        dlen = $urandom;
                    end
                    2: begin
                        tlen = $urandom_range(64, 0);
                        dlen = $urandom_range(64, 0);
                    end
                    default: entry = tlen + $urandom_range(64, 0);
                endcase
            end
            add_image(1'b1, magic, tlen, dlen, entry, bad_t, bad_d, body, keep, emitted);
            image_words += emitted;
            if ($urandom_range(3, 0) == 0) begin
                repeat ($urandom_range(3, 1)) add_flash_word($urandom, 1'b0, 1'b0, '0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx        = 0;
        burst_left = 0;
        while (idx < flash_stream.size()) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(30, 1);
                gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                if (gap > 0) begin
                    in_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (idx == random_start) begin
                in_bus.valid <= 1'b0;
                @(posedge i_clk);
                while (ram_cmds_due.size() != 0) @(posedge i_clk);
            end
            in_bus.valid      <= 1'b1;
            in_bus.flash_word <= flash_stream[idx].word;
            in_bus.restart    <= flash_stream[idx].restart;
            do @(posedge i_clk); while (!in_bus.ready);
            idx++;
            burst_left--;
        end
        in_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (ram_cmds_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_n == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
